>>> hw/rtl/xee_pkg.sv
`timescale 1ns / 1ps

package xee_pkg;

    localparam int XEE_MAX_OUT     = 6;
    localparam int XEE_HELD_DEPTH  = 4;
    localparam int XEE_HELD_AW     = $clog2(XEE_HELD_DEPTH);
    localparam int XEE_QUEUE_DEPTH = 2;
    localparam int XEE_NUM_ENT     = 4;
    localparam int XEE_TAIL_MAX    = 5;
    localparam int XEE_CNT_W       = 3;
    localparam int XEE_ENT_W       = $clog2(XEE_NUM_ENT);

    localparam logic [7:0] CH_AMP = 8'h26;

    localparam logic [7:0] ENT_CHAR [XEE_NUM_ENT] = '{8'h3C, 8'h3E, 8'h26, 8'h22};

    localparam logic [XEE_CNT_W-1:0] ENT_LEN [XEE_NUM_ENT] = '{3'd3, 3'd3, 3'd4, 3'd5};

    localparam logic [7:0] ENT_TAIL [XEE_NUM_ENT][XEE_TAIL_MAX] = '{
        '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}
    };

    typedef struct packed {
        logic [XEE_MAX_OUT-1:0][7:0] data;
        logic [XEE_CNT_W-1:0]        count;
        logic                        last;
    } job_t;

    function automatic logic [7:0] tail_at(input logic [XEE_ENT_W-1:0] k,
                                           input logic [XEE_CNT_W-1:0] i);
        logic [7:0] r;
        r = '0;
        if (i < XEE_CNT_W'(XEE_TAIL_MAX))
        begin
            r = ENT_TAIL[k][i];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/xee_front.sv
`timescale 1ns / 1ps

module xee_front
    import xee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       job_push,
    output job_t       job
);

    logic                       mode_reg;
    logic [XEE_CNT_W-1:0]       held_count_reg;
    logic [XEE_CNT_W-1:0]       held_count_next;
    logic [7:0]                 held_bytes_reg [XEE_HELD_DEPTH];

    logic [XEE_CNT_W-1:0]        pos;
    logic [XEE_NUM_ENT-1:0]      pre_ok;
    logic [XEE_NUM_ENT-1:0]      hit;
    logic                        hit_any;
    logic [XEE_ENT_W-1:0]        hit_k;
    logic                        complete;
    logic                        esc_any;
    logic [XEE_ENT_W-1:0]        esc_k;
    logic                        store_b;
    logic                        accept;
    logic [XEE_MAX_OUT-1:0][7:0] flush_seq;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign job_push  = in_valid && !q_full && (job.count != '0);

    always_comb
    begin
        pos = held_count_reg - XEE_CNT_W'(1);
        for (int k = 0; k < XEE_NUM_ENT; k++)
        begin
            pre_ok[k] = (pos < ENT_LEN[k]);
            for (int i = 0; i < XEE_HELD_DEPTH; i++)
            begin
                if ((XEE_CNT_W'(i) < pos) &&
                    (held_bytes_reg[i] != tail_at(XEE_ENT_W'(k), XEE_CNT_W'(i))))
                begin
                    pre_ok[k] = 1'b0;
                end
            end
            hit[k] = pre_ok[k] && (tail_at(XEE_ENT_W'(k), pos) == in_byte);
        end

        hit_any = 1'b0;
        hit_k   = '0;
        esc_any = 1'b0;
        esc_k   = '0;
        for (int k = XEE_NUM_ENT - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                hit_any = 1'b1;
                hit_k   = XEE_ENT_W'(k);
            end
            if (in_byte == ENT_CHAR[k])
            begin
                esc_any = 1'b1;
                esc_k   = XEE_ENT_W'(k);
            end
        end
        complete = ((pos + XEE_CNT_W'(1)) == ENT_LEN[hit_k]);

        flush_seq[0] = CH_AMP;
        for (int i = 0; i < XEE_HELD_DEPTH; i++)
        begin
            flush_seq[i + 1] = held_bytes_reg[i];
        end
        flush_seq[XEE_MAX_OUT - 1] = in_byte;

        job.data        = '0;
        job.count       = '0;
        job.last        = in_last;
        held_count_next = held_count_reg;
        store_b         = 1'b0;

        if (!mode_reg)
        begin
            held_count_next = '0;
            if (esc_any)
            begin
                job.data[0] = CH_AMP;
                for (int i = 0; i < XEE_TAIL_MAX; i++)
                begin
                    job.data[i + 1] = tail_at(esc_k, XEE_CNT_W'(i));
                end
                job.count = ENT_LEN[esc_k] + XEE_CNT_W'(1);
            end
            else
            begin
                job.data[0] = in_byte;
                job.count   = XEE_CNT_W'(1);
            end
        end
        else if ((held_count_reg != '0) && hit_any && complete)
        begin
            job.data[0]     = ENT_CHAR[hit_k];
            job.count       = XEE_CNT_W'(1);
            held_count_next = '0;
        end
        else if ((held_count_reg != '0) && hit_any && !in_last)
        begin
            store_b         = 1'b1;
            held_count_next = held_count_reg + XEE_CNT_W'(1);
        end
        else if ((in_byte == CH_AMP) && !in_last)
        begin
            job.data        = flush_seq;
            job.count       = held_count_reg;
            held_count_next = XEE_CNT_W'(1);
        end
        else
        begin
            for (int i = 0; i < XEE_MAX_OUT; i++)
            begin
                job.data[i] = (XEE_CNT_W'(i) == held_count_reg) ? in_byte : flush_seq[i];
            end
            job.count       = held_count_reg + XEE_CNT_W'(1);
            held_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            held_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg       <= mode;
            held_count_reg <= '0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_b && (pos < XEE_CNT_W'(XEE_HELD_DEPTH)))
        begin
            held_bytes_reg[pos[XEE_HELD_AW-1:0]] <= in_byte;
        end
    end

endmodule

>>> hw/rtl/xee_queue.sv
`timescale 1ns / 1ps

module xee_queue
    import xee_pkg::*;
#(
    parameter int DEPTH = XEE_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/xee_back.sv
`timescale 1ns / 1ps

module xee_back
    import xee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [XEE_CNT_W-1:0] idx_reg;
    logic [XEE_CNT_W-1:0] idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;
    logic                 load;
    logic                 final_beat;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        load       = head_valid && (!out_valid_reg || out_ready);
        final_beat = (idx_reg == (head.count - XEE_CNT_W'(1)));
        pop        = load && final_beat;
        idx_next   = idx_reg;
        if (load)
        begin
            idx_next = final_beat ? '0 : idx_reg + XEE_CNT_W'(1);
        end
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head.data[idx_reg];
            out_last_reg <= head.last && final_beat;
        end
    end

endmodule

>>> hw/rtl/xml_entity_escape_unescape_core.sv
// The first result beat passes through a job queue slot and the back serializer's output
// register before it shows on out_valid. Throughput: one result beat per cycle while
// out_ready is high; an item of N beats (N from 1 to 6) is sent whole before the next job.
// Input takes one beat per cycle while the job queue between front and back has room.
// Reset (rst_n low, asynchronous) selects escape mode, drops any held partial entity,
// empties the job queue and clears out_valid.
`timescale 1ns / 1ps

module xml_entity_escape_unescape_core
    import xee_pkg::*;
#(
    parameter int QUEUE_DEPTH = XEE_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    job_t front_job;
    job_t head_job;
    logic job_push;
    logic q_full;
    logic q_pop;
    logic q_valid;

    xee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .mode      (mode),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .q_full    (q_full),
        .job_push  (job_push),
        .job       (front_job)
    );

    xee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (front_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (head_job)
    );

    xee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (head_job),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule

>>> hw/rtl/xee_checker.sv
`timescale 1ns / 1ps

module xee_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
        else $error("result beat changed while stalled");

    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result beat pending");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind xml_entity_escape_unescape_core xee_checker u_xee_checker (.*);
